// ===== hdl/mnhp_pkg.sv =====
// Shared types and constants for the mouse nibble handshake port.
// No dependencies; imported by every module of the block.
package mnhp_pkg;

   localparam int AXIS_BITS  = 13;
   localparam int DELAY_BITS = 16;

   // stream word widths, fields packed from bit 0 and padded to whole bytes
   localparam int REQ_FIELD_BITS = 2 + 2 * AXIS_BITS + 4;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 7;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [15:0] DATA_DELAY_RESET = 16'd72;
   localparam logic [15:0] ACK_DELAY_RESET  = 16'd48;

   localparam logic [5:0] PORT_IDLE     = 6'h30;
   localparam logic [5:0] PORT_SELECTED = 6'h3b;
   localparam logic [5:0] PORT_ACK_BIT  = 6'h10;
   localparam logic [3:0] NIBBLE_ID     = 4'hf;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_DATA_DELAY = 1'b0,
      REG_ACK_DELAY  = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type             opcode;
      logic                   select_level;
      logic                   request_level;
      logic [AXIS_BITS-1:0]   pos_x;
      logic [AXIS_BITS-1:0]   pos_y;
      logic [3:0]             button_bits;
   } item_type;

   typedef struct packed {
      logic [5:0] port_value;
      logic       busy_res;
   } result_type;

   typedef struct packed {
      logic ack;    // pending update is the acknowledge line
      logic level;  // request level being answered
   } delay_kind_type;

endpackage

// ===== hdl/mouse_nibble_handshake_port.sv =====
// Top level of the mouse nibble handshake port: stream ports, delay registers,
// input and result registers around mnhp_core. Depends on mnhp_pkg, mnhp_core.
//
//  channel | direction | payload
//  --------+-----------+--------------------------------------------------------
//  req     | in        | tuser: opcode; tdata: select, request, pos_x, pos_y, buttons
//  rsp     | out       | tdata: port_value, busy_res
//  csr     | in        | index 0 data delay ticks, index 1 ack delay ticks
//
// One word per clock sustained while rsp_tready stays high; a word passes the input register
// and then leaves from the result register.
// The state update of the handshake is the single step between the two registers.
// Reset is synchronous and restores both delays to their defaults.
// A stalled result holds rsp_tdata; req_tready drops only when both registers are full.
module mouse_nibble_handshake_port (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // select_level, request_level, pos_x, pos_y, button_bits (from bit 0 up)
   input  logic [mnhp_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // opcode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // port_value, busy_res (from bit 0 up)
   output logic [mnhp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [mnhp_pkg::DELAY_BITS-1:0]    csr_wdata
);
   import mnhp_pkg::*;

   localparam int POS_X_LSB = 2;
   localparam int POS_Y_LSB = POS_X_LSB + AXIS_BITS;
   localparam int BTN_LSB   = POS_Y_LSB + AXIS_BITS;

   logic                  in_valid_ff,  in_valid_in;
   item_type              in_item_ff,   in_item_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_data_ff,  out_data_in;
   logic [DELAY_BITS-1:0] data_delay_ff, data_delay_in;
   logic [DELAY_BITS-1:0] ack_delay_ff,  ack_delay_in;

   logic       advance;
   logic       req_take;
   result_type core_result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.opcode        = opcode_type'(req_tuser);
      in_item_in.select_level  = req_tdata[0];
      in_item_in.request_level = req_tdata[1];
      in_item_in.pos_x         = req_tdata[POS_X_LSB +: AXIS_BITS];
      in_item_in.pos_y         = req_tdata[POS_Y_LSB +: AXIS_BITS];
      in_item_in.button_bits   = req_tdata[BTN_LSB +: 4];
      if (!req_take) begin
         in_item_in = in_item_ff;
      end
      in_valid_in = req_take || (in_valid_ff && !advance);
   end

   always_comb begin
      out_data_in  = advance ? core_result : out_data_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_comb begin
      data_delay_in = data_delay_ff;
      ack_delay_in  = ack_delay_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_DATA_DELAY: data_delay_in = csr_wdata;
            REG_ACK_DELAY:  ack_delay_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         data_delay_ff <= DATA_DELAY_RESET;
         ack_delay_ff  <= ACK_DELAY_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         data_delay_ff <= data_delay_in;
         ack_delay_ff  <= ack_delay_in;
      end
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   mnhp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .item       (in_item_ff),
      .data_delay (data_delay_ff),
      .ack_delay  (ack_delay_ff),
      .result     (core_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - RSP_FIELD_BITS)'(0),
                        out_data_ff.busy_res, out_data_ff.port_value};

endmodule

// ===== hdl/mnhp_core.sv =====
// Handshake state, delay timer and nibble selection of the mouse port.
// Depends on mnhp_pkg; advances one item per cycle when step_en is high.
module mnhp_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  mnhp_pkg::item_type          item,
   input  logic [mnhp_pkg::DELAY_BITS-1:0] data_delay,
   input  logic [mnhp_pkg::DELAY_BITS-1:0] ack_delay,
   output mnhp_pkg::result_type        result
);
   import mnhp_pkg::*;

   logic                  select_ff,  select_in;
   logic                  request_ff, request_in;
   logic [5:0]            port_ff,    port_in;
   logic [1:0]            phase_ff,   phase_in;
   logic [AXIS_BITS-1:0]  last_x_ff,  last_x_in;
   logic [AXIS_BITS-1:0]  last_y_ff,  last_y_in;
   logic [AXIS_BITS:0]    delta_x_ff, delta_x_in;
   logic [AXIS_BITS:0]    delta_y_ff, delta_y_in;
   logic                  active_ff,  active_in;
   logic [DELAY_BITS-1:0] left_ff,    left_in;
   delay_kind_type        kind_ff,    kind_in;

   logic [AXIS_BITS:0]    wrap_x;
   logic [AXIS_BITS:0]    wrap_y;
   logic [AXIS_BITS:0]    delta_sel;
   logic [3:0]            nibble;

   // Difference of two wrapping counters, folded into -HALF..+HALF.
   function automatic logic [AXIS_BITS:0] wrap_delta(
      input logic [AXIS_BITS-1:0] now_pos,
      input logic [AXIS_BITS-1:0] old_pos
   );
      logic signed [AXIS_BITS+1:0] diff;
      logic signed [AXIS_BITS+1:0] half;
      logic signed [AXIS_BITS+1:0] full;
      diff = $signed({2'b00, now_pos}) - $signed({2'b00, old_pos});
      half = $signed((AXIS_BITS+2)'(1) <<< (AXIS_BITS - 1));
      full = $signed((AXIS_BITS+2)'(1) <<< AXIS_BITS);
      if (diff > half) begin
         diff = diff - full;
      end else if (diff < -half) begin
         diff = diff + full;
      end
      return diff[AXIS_BITS:0];
   endfunction

   // True when the delta does not fit a 9-bit signed value.
   function automatic logic out_of_range(input logic [AXIS_BITS:0] d);
      return !((&d[AXIS_BITS:8]) || !(|d[AXIS_BITS:8]));
   endfunction

   assign wrap_x    = wrap_delta(item.pos_x, last_x_ff);
   assign wrap_y    = wrap_delta(item.pos_y, last_y_ff);
   assign delta_sel = phase_ff[0] ? delta_y_ff : delta_x_ff;

   always_comb begin
      plain_nibble: begin
         nibble = 4'h0;
         case (phase_ff)
            2'd0: nibble = NIBBLE_ID;
            2'd1: begin
               if (kind_ff.level) begin
                  nibble = item.button_bits;
               end else begin
                  nibble = {out_of_range(delta_y_ff), out_of_range(delta_x_ff),
                            delta_y_ff[8], delta_x_ff[8]};
               end
            end
            default: nibble = kind_ff.level ? delta_sel[3:0] : delta_sel[7:4];
         endcase
      end
   end

   always_comb begin
      select_in  = select_ff;
      request_in = request_ff;
      port_in    = port_ff;
      phase_in   = phase_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      delta_x_in = delta_x_ff;
      delta_y_in = delta_y_ff;
      active_in  = active_ff;
      left_in    = left_ff;
      kind_in    = kind_ff;
      if (step_en) begin
         if (item.opcode == OP_TICK) begin
            if (active_ff) begin
               if (left_ff <= DELAY_BITS'(1)) begin
                  active_in = 1'b0;
                  if (kind_ff.ack) begin
                     port_in = kind_ff.level ? (port_ff | PORT_ACK_BIT)
                                             : (port_ff & ~PORT_ACK_BIT);
                     // answer a request toggle that arrived while busy
                     if (kind_ff.level != request_ff) begin
                        active_in = 1'b1;
                        left_in   = data_delay;
                        kind_in   = '{ack: 1'b0, level: request_ff};
                     end
                  end else begin
                     if (phase_ff == 2'd0 && !kind_ff.level) begin
                        last_x_in  = item.pos_x;
                        last_y_in  = item.pos_y;
                        delta_x_in = wrap_x;
                        delta_y_in = wrap_y;
                     end
                     port_in = (port_ff & PORT_IDLE) | {2'b00, nibble};
                     if (kind_ff.level) begin
                        phase_in = phase_ff + 2'd1;
                     end
                     active_in = 1'b1;
                     left_in   = ack_delay;
                     kind_in   = '{ack: 1'b1, level: kind_ff.level};
                  end
               end else begin
                  left_in = left_ff - DELAY_BITS'(1);
               end
            end
         end else if (item.select_level != select_ff) begin
            if (item.select_level) begin
               active_in = 1'b0;
               port_in   = PORT_IDLE;
               phase_in  = 2'd0;
            end else begin
               port_in = PORT_SELECTED;
               if (!item.request_level) begin
                  active_in = 1'b1;
                  left_in   = data_delay;
                  kind_in   = '{ack: 1'b0, level: 1'b0};
               end
            end
            select_in  = item.select_level;
            request_in = item.request_level;
         end else if (!select_ff && item.request_level != request_ff) begin
            if (!active_ff) begin
               active_in = 1'b1;
               left_in   = data_delay;
               kind_in   = '{ack: 1'b0, level: item.request_level};
            end
            request_in = item.request_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff  <= 1'b1;
         request_ff <= 1'b1;
         port_ff    <= PORT_IDLE;
         phase_ff   <= 2'd0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         delta_x_ff <= '0;
         delta_y_ff <= '0;
         active_ff  <= 1'b0;
         left_ff    <= '0;
         kind_ff    <= '0;
      end else begin
         select_ff  <= select_in;
         request_ff <= request_in;
         port_ff    <= port_in;
         phase_ff   <= phase_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         delta_x_ff <= delta_x_in;
         delta_y_ff <= delta_y_in;
         active_ff  <= active_in;
         left_ff    <= left_in;
         kind_ff    <= kind_in;
      end
   end

   // result reflects the state after this item
   assign result.port_value = port_in;
   assign result.busy_res   = active_in;

endmodule

// ===== hdl/mnhp_checker.sv =====
// Port-level checks for mouse_nibble_handshake_port, attached by bind.
// Depends on mnhp_pkg for the stream widths.
module mnhp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [mnhp_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import mnhp_pkg::*;

   // hold the result word while it is stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // port bit 5 is tied high in every state
   a_fixed_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5])
      else $error("port bit 5 low in a result word");

   // reset drops any word in flight
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // the input stalls only behind a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without result backpressure");

endmodule

bind mouse_nibble_handshake_port mnhp_checker u_mnhp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
